// File: rtl/pkvx_pkg.sv
// ---------------------------------------------------------------------------
// pkvx_pkg
// Types and codes shared by the paged KV slot mapper and query expander.
// ---------------------------------------------------------------------------
package pkvx_pkg;

  // input commands
  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_START   = 2'd1;
  localparam logic [1:0] CMD_CONTEXT = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_CONTEXT = 2'd0;
  localparam logic [1:0] KIND_QUERY   = 2'd1;
  localparam logic [1:0] KIND_SAMPLE  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_BLOCK_SIZE = 3'd0;
  localparam logic [2:0] REG_ENTRIES    = 3'd1;
  localparam logic [2:0] REG_QUERIES    = 3'd2;
  localparam logic [2:0] REG_SAMPLES    = 3'd3;
  localparam logic [2:0] REG_MASK_TOKEN = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  request_index;
    logic [5:0]  table_entry;
    logic [30:0] block_id;
    logic [19:0] context_count;
    logic [19:0] rejected_count;
    logic [30:0] next_token_id;
    logic [30:0] position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] position_res;
    logic signed [31:0] slot;
    logic [30:0]        token_id;
    logic [10:0]        token_index;
    logic               last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_MUL,
    ST_EMIT,
    ST_QNEXT,
    ST_SAMPLE
  } state_t;

endpackage

// File: rtl/pkvx_div.sv
// ---------------------------------------------------------------------------
// pkvx_div
// Restoring divider, 32-bit dividend by 17-bit divisor, one quotient bit
// per cycle. Done is registered and pulses in the cycle after the last step.
// ---------------------------------------------------------------------------
module pkvx_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] dividend,
  input  logic [16:0] divisor,
  output logic        done,
  output logic [31:0] quotient,
  output logic [16:0] remainder
);

  logic [31:0] dvd_r, dvd_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [16:0] dvs_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [17:0] trial;

  // one restoring step; go loads the operands and idle holds them
  always_comb begin
    trial    = {rem_r, dvd_r[31]};
    dvd_nxt  = {dvd_r[30:0], 1'b0};
    rem_nxt  = trial[16:0];
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (go) begin
      dvd_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt    = 17'(trial - {1'b0, dvs_r});
        dvd_nxt[0] = 1'b1;
      end
      cnt_nxt = 6'(cnt_r + 6'd1);
      if (cnt_r == 6'd31) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end else begin
      dvd_nxt = dvd_r;
      rem_nxt = rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    if (go) dvs_r <= divisor;
  end

  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

// File: rtl/paged_kv_slot_and_query_expander.sv
// ---------------------------------------------------------------------------
// paged_kv_slot_and_query_expander
// Maps context token positions to paged cache slots and expands each
// finished request into query tokens and sample indices.
// ---------------------------------------------------------------------------
// Table writes, and start words with context tokens to follow, leave the
// block idle; a start word with an empty context goes straight on to its
// query tokens. Each context token and each query token passes through the
// bit-serial divider that splits the position by the block size, then a
// table read, a multiply and the one-cycle result. Sample indices follow
// one per cycle. Results are shown for exactly one cycle on out_valid and
// cannot be held off; busy stays high until the last result of the word
// has gone out.
module paged_kv_slot_and_query_expander #(
  parameter int MAX_REQUESTS      = 16,
  parameter int MAX_TABLE_ENTRIES = 64,
  parameter int MAX_QUERIES       = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  pkvx_pkg::in_item_t   in_data,
  output logic                 out_valid,
  output pkvx_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [30:0]          cfg_data
);
  import pkvx_pkg::*;

  localparam int DEPTH = MAX_REQUESTS * MAX_TABLE_ENTRIES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic [16:0] bs_r;
  logic [6:0]  ent_r;
  logic [5:0]  qry_r;
  logic [4:0]  smp_r;
  logic [30:0] mask_r;

  // request state
  logic [3:0]  req_r;
  logic [19:0] left_r;
  logic [19:0] rej_r;
  logic [30:0] lastpos_r;
  logic [30:0] ntok_r;
  logic        fin_r;
  logic        isq_r;
  logic [5:0]  qi_r;
  logic [4:0]  si_r;

  // datapath
  logic [31:0] pos_r;
  logic [AW-1:0] addr_r;
  logic [16:0] off_r;
  logic        zero_id_r;
  logic [30:0] rd_r;
  logic [31:0] slot_r;

  logic [30:0] mem [DEPTH];

  state_t state_r, state_nxt;

  logic        accept, acc_ctx, div_go, div_done;
  logic [31:0] quot;
  logic [16:0] rem;
  logic [16:0] bs_eff;
  logic [10:0] lim;
  logic [31:0] idx;
  logic [5:0]  qn;
  logic [10:0] base;
  logic [31:0] qpos;
  logic [31:0] prod;

  // effective settings
  always_comb begin
    bs_eff = (bs_r == '0) ? 17'd1 : bs_r;
    if (ent_r == '0)                             lim = 11'd0;
    else if (int'(ent_r) > MAX_TABLE_ENTRIES)    lim = 11'(MAX_TABLE_ENTRIES - 1);
    else                                         lim = 11'(ent_r - 7'd1);
    qn   = (int'(qry_r) > MAX_QUERIES) ? 6'(MAX_QUERIES) : qry_r;
    base = 11'(req_r) * 11'(qn);
    qpos = 32'({1'b0, lastpos_r} + 32'd1 + 32'(qi_r));
    idx  = (quot > 32'(lim)) ? 32'(lim) : quot;
    prod = 32'(rd_r) * 32'(bs_eff);
  end

  assign accept  = start && !busy;
  assign acc_ctx = accept && in_data.cmd == CMD_CONTEXT && left_r != '0;
  assign div_go  = acc_ctx || (state_r == ST_QNEXT && qi_r < qn);

  pkvx_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (div_go),
    .dividend  (acc_ctx ? {1'b0, in_data.position} : qpos),
    .divisor   (bs_eff),
    .done      (div_done),
    .quotient  (quot),
    .remainder (rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc_ctx) state_nxt = ST_DIV;
        else if (accept && in_data.cmd == CMD_START && in_data.context_count == '0)
          state_nxt = ST_QNEXT;
      end
      ST_DIV:  if (div_done) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (isq_r || fin_r) state_nxt = ST_QNEXT;
        else                state_nxt = ST_IDLE;
      end
      ST_QNEXT: begin
        if (qi_r < qn)         state_nxt = ST_DIV;
        else if (smp_r != '0)  state_nxt = ST_SAMPLE;
        else                   state_nxt = ST_IDLE;
      end
      ST_SAMPLE: if (si_r == 5'(smp_r - 5'd1)) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy      = (state_r != ST_IDLE);
    out_valid = (state_r == ST_EMIT) || (state_r == ST_SAMPLE);
    cfg_ready = 1'b1;
    out_data  = '0;
    if (state_r == ST_SAMPLE) begin
      out_data.kind        = KIND_SAMPLE;
      out_data.token_index = 11'(base + 11'd1 + 11'(si_r));
      out_data.last        = (si_r == 5'(smp_r - 5'd1));
    end else if (isq_r) begin
      out_data.kind         = KIND_QUERY;
      out_data.position_res = pos_r;
      out_data.slot         = slot_r;
      out_data.token_id     = (qi_r == '0) ? ntok_r : mask_r;
      out_data.token_index  = 11'(base + 11'(qi_r));
      out_data.last         = (qi_r == 6'(qn - 6'd1)) && smp_r == '0;
    end else begin
      out_data.kind         = KIND_CONTEXT;
      out_data.position_res = pos_r;
      out_data.slot         = slot_r;
      out_data.last         = !fin_r || (qn == '0 && smp_r == '0);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      bs_r      <= 17'd128;
      ent_r     <= 7'd64;
      qry_r     <= 6'd4;
      smp_r     <= 5'd3;
      mask_r    <= '0;
      req_r     <= '0;
      left_r    <= '0;
      rej_r     <= '0;
      lastpos_r <= '0;
      ntok_r    <= '0;
      fin_r     <= 1'b0;
      isq_r     <= 1'b0;
      qi_r      <= '0;
      si_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BLOCK_SIZE: bs_r   <= cfg_data[16:0];
          REG_ENTRIES:    ent_r  <= cfg_data[6:0];
          REG_QUERIES:    qry_r  <= cfg_data[5:0];
          REG_SAMPLES:    smp_r  <= cfg_data[4:0];
          REG_MASK_TOKEN: mask_r <= cfg_data;
          default: ;
        endcase
      end
      if (accept && in_data.cmd == CMD_START) begin
        req_r     <= in_data.request_index;
        left_r    <= in_data.context_count;
        rej_r     <= in_data.rejected_count;
        ntok_r    <= in_data.next_token_id;
        lastpos_r <= '0;
        isq_r     <= 1'b0;
        qi_r      <= '0;
        si_r      <= '0;
      end
      if (acc_ctx) begin
        if (left_r > rej_r) lastpos_r <= in_data.position;
        left_r <= 20'(left_r - 20'd1);
        fin_r  <= (left_r == 20'd1);
        isq_r  <= 1'b0;
        qi_r   <= '0;
        si_r   <= '0;
      end
      if (state_r == ST_QNEXT) isq_r <= 1'b1;
      if (state_r == ST_EMIT && isq_r) qi_r <= 6'(qi_r + 6'd1);
      if (state_r == ST_SAMPLE) si_r <= 5'(si_r + 5'd1);
    end
  end

  // datapath and table
  always_ff @(posedge clk) begin
    if (div_go) pos_r <= acc_ctx ? {1'b0, in_data.position} : qpos;
    if (state_r == ST_DIV && div_done) begin
      addr_r    <= AW'(int'(req_r) * MAX_TABLE_ENTRIES + int'(idx[10:0]));
      off_r     <= rem;
      zero_id_r <= (int'(req_r) >= MAX_REQUESTS);
    end
    if (state_r == ST_RD) rd_r <= mem[addr_r];
    if (state_r == ST_MUL) slot_r <= (zero_id_r ? 32'd0 : prod) + 32'(off_r);
    if (accept && in_data.cmd == CMD_WRITE &&
        int'(in_data.request_index) < MAX_REQUESTS &&
        int'(in_data.table_entry) < MAX_TABLE_ENTRIES)
      mem[AW'(int'(in_data.request_index) * MAX_TABLE_ENTRIES +
              int'(in_data.table_entry))] <= in_data.block_id;
  end

`ifndef SYNTH
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result strobe while idle");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV) else $error("divider finished outside wait");
  a_emit_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> $past(state_r) == ST_MUL) else $error("slot shown too early");
`endif

endmodule
